// File: hdl/sedrv_pkg.sv
package sedrv_pkg;

    // default chain capacity in register bytes
    localparam int MAX_BYTES_DEF = 4;

    // depth of the command queue between front and back
    localparam int Q_DEPTH = 2;

    // bits in one register byte
    localparam int BYTE_BITS = 8;

    // full-scale clamp limits for the analog reply
    localparam logic [4:0] ABITS_MIN = 5'd1;
    localparam logic [4:0] ABITS_MAX = 5'd16;

    // register addresses of the configuration port (word index)
    localparam logic REG_CHAIN_BYTES = 1'b0;
    localparam logic REG_ANALOG_BITS = 1'b1;

    // reset values of the configuration registers
    localparam logic [2:0] CHAIN_BYTES_RST = 3'd4;
    localparam logic [4:0] ANALOG_BITS_RST = 5'd10;

    // request codes
    typedef enum logic [2:0] {
        ACT_SHIFT_BIT  = 3'd0,
        ACT_SHIFT_BYTE = 3'd1,
        ACT_LATCH      = 3'd2,
        ACT_WRITE_PIN  = 3'd3,
        ACT_MASK_BYTE  = 3'd4,
        ACT_READ_PIN   = 3'd5,
        ACT_UPLOAD     = 3'd6
    } t_action;

    // result kinds
    localparam logic [1:0] KIND_SERIAL = 2'd0;
    localparam logic [1:0] KIND_LATCH  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // configuration seen by the front
    typedef struct packed {
        logic [2:0] chain_bytes;
        logic [4:0] analog_bits;
    } t_cfg;

    // what follows the serial bits of one command
    typedef struct packed {
        logic        latch;
        logic        rd;
        logic        level;
        logic [15:0] analog;
    } t_tail_ctl;

    // back sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BITS,
        BK_TAIL
    } t_bk_state;

endpackage

// File: hdl/sipo_expander_shadow_driver_core.sv
// Shadow driver for a chain of 8-bit serial-in parallel-out registers.
// Requests enter on the input channel (i_in_valid / o_in_ready) as one
// transaction each; every request turns into zero or more line events on
// the output channel (o_out_valid / i_out_ready): serial bits with a shift
// clock, latch pulses and read replies, with o_last on the final event.
// Configuration (chain length, analog resolution) is written over the APB
// port; the user must write it only while the block is idle, the block itself does not enforce it.
// Flow: a request is classified in the cycle it is accepted and queued;
// the back pops a command into its working registers and then emits one
// event per cycle into the output register while the output slot is free.
// A pin or masked write on a full 4-byte chain gives 32 bits plus latch.
// The front accepts new requests while the two-entry command queue has
// room, so it can take new requests before the back is through with the
// last one.
// Reset clears the shadow, the queue and the output register and loads
// the default configuration. When the receiver stalls, the held event stays
// put, the back stops, the queue fills and the input channel stalls.
module sipo_expander_shadow_driver_core
    import sedrv_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic [4:0]  i_pin,
    input  logic        i_value_bit,
    input  logic [1:0]  i_byte_from_end,
    input  logic        i_final_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic        o_serial_bit,
    output logic        o_read_level,
    output logic [15:0] o_read_analog,
    output logic        o_last
);

    localparam int DATA_W = MAX_BYTES * BYTE_BITS;
    localparam int CNT_W = $clog2(DATA_W + 1);
    localparam int ENT_W = CNT_W + DATA_W + $bits(t_tail_ctl);

    t_cfg             cfg;
    logic             q_full;
    logic             q_push;
    logic [ENT_W-1:0] q_wdata;
    logic             q_valid;
    logic             q_pop;
    logic [ENT_W-1:0] q_rdata;

    // configuration registers
    sedrv_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // front: shadow update and command classification
    sedrv_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_pin           (i_pin),
        .i_value_bit     (i_value_bit),
        .i_byte_from_end (i_byte_from_end),
        .i_final_item    (i_final_item),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_entry         (q_wdata)
    );

    // command queue between front and back
    sedrv_queue #(
        .WIDTH (ENT_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    // back: event sequencer and output register
    sedrv_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_entry       (q_rdata),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_serial_bit  (o_serial_bit),
        .o_read_level  (o_read_level),
        .o_read_analog (o_read_analog),
        .o_last        (o_last)
    );

endmodule

// File: hdl/sedrv_regs.sv
module sedrv_regs
    import sedrv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [2:0] r_chain_bytes;
    logic [4:0] r_analog_bits;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_bytes <= CHAIN_BYTES_RST;
            r_analog_bits <= ANALOG_BITS_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_CHAIN_BYTES: r_chain_bytes <= pwdata[2:0];
                REG_ANALOG_BITS: r_analog_bits <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        unique case (paddr[2])
            REG_CHAIN_BYTES: prdata = {29'd0, r_chain_bytes};
            REG_ANALOG_BITS: prdata = {27'd0, r_analog_bits};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg.chain_bytes = r_chain_bytes;
    assign o_cfg.analog_bits = r_analog_bits;

endmodule

// File: hdl/sedrv_front.sv
module sedrv_front
    import sedrv_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF,
    localparam int DATA_W = MAX_BYTES * BYTE_BITS,
    localparam int CNT_W = $clog2(DATA_W + 1),
    localparam int ENT_W = CNT_W + DATA_W + $bits(t_tail_ctl)
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [2:0]       i_action,
    input  logic [7:0]       i_data_byte,
    input  logic [4:0]       i_pin,
    input  logic             i_value_bit,
    input  logic [1:0]       i_byte_from_end,
    input  logic             i_final_item,
    input  logic             i_q_full,
    output logic             o_push,
    output logic [ENT_W-1:0] o_entry
);

    localparam int LEN_W = $clog2(MAX_BYTES + 1);

    logic [7:0]       r_shadow [MAX_BYTES];
    logic [7:0]       n_shadow [MAX_BYTES];
    logic [7:0]       nxt_byte [MAX_BYTES];
    logic [LEN_W-1:0] len;
    logic [3:0]       len4;
    logic             pin_ok;
    logic [3:0]       pin_idx;
    logic             bfe_ok;
    logic [3:0]       bfe_idx;
    logic [7:0]       pin_mask;
    logic             rd_level;
    logic [4:0]       abits;
    logic [15:0]      full_scale;
    logic [DATA_W-1:0] upl_data;
    logic             has_res;
    logic [CNT_W-1:0] nbits;
    logic [DATA_W-1:0] data;
    t_tail_ctl        ctl;
    logic             accept;

    // effective chain length and decoded positions
    always_comb begin
        if (i_cfg.chain_bytes > 3'(MAX_BYTES)) begin
            len = LEN_W'(MAX_BYTES);
        end else begin
            len = LEN_W'(i_cfg.chain_bytes);
        end
        len4     = 4'(len);
        pin_ok   = (len4 != 4'd0) && (4'(i_pin[4:3]) < len4);
        pin_idx  = len4 - 4'(i_pin[4:3]) - 4'd1;
        bfe_ok   = 4'(i_byte_from_end) < len4;
        bfe_idx  = len4 - 4'(i_byte_from_end) - 4'd1;
        pin_mask = 8'd1 << i_pin[2:0];
    end

    // neighbor byte feeding each shadow byte on a shift
    always_comb begin
        for (int i = 0; i < MAX_BYTES - 1; i++) begin
            nxt_byte[i] = r_shadow[i + 1];
        end
        nxt_byte[MAX_BYTES - 1] = 8'h00;
    end

    // shadow bit of the pin being read
    always_comb begin
        rd_level = 1'b0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            if (pin_ok && pin_idx == 4'(i)) begin
                rd_level = r_shadow[i][i_pin[2:0]];
            end
        end
    end

    // analog full scale, resolution clamped to 1..16
    always_comb begin
        if (i_cfg.analog_bits < ABITS_MIN) begin
            abits = ABITS_MIN;
        end else if (i_cfg.analog_bits > ABITS_MAX) begin
            abits = ABITS_MAX;
        end else begin
            abits = i_cfg.analog_bits;
        end
        full_scale = ~(16'hFFFF << abits);
    end

    // shadow update for the current request
    always_comb begin
        n_shadow = r_shadow;
        for (int i = 0; i < MAX_BYTES; i++) begin
            unique case (i_action)
                ACT_SHIFT_BIT: begin
                    if (4'(i) + 4'd1 < len4) begin
                        n_shadow[i] = {r_shadow[i][6:0], nxt_byte[i][7]};
                    end else if (4'(i) + 4'd1 == len4) begin
                        n_shadow[i] = {r_shadow[i][6:0], i_value_bit};
                    end
                end
                ACT_SHIFT_BYTE: begin
                    if (4'(i) + 4'd1 < len4) begin
                        n_shadow[i] = nxt_byte[i];
                    end else if (4'(i) + 4'd1 == len4) begin
                        n_shadow[i] = i_data_byte;
                    end
                end
                ACT_WRITE_PIN: begin
                    if (pin_ok && pin_idx == 4'(i)) begin
                        n_shadow[i] = i_value_bit ? (r_shadow[i] | pin_mask)
                                                  : (r_shadow[i] & ~pin_mask);
                    end
                end
                ACT_MASK_BYTE: begin
                    if (bfe_ok && bfe_idx == 4'(i)) begin
                        n_shadow[i] = i_value_bit ? (r_shadow[i] | i_data_byte)
                                                  : (r_shadow[i] & ~i_data_byte);
                    end
                end
                default: ;
            endcase
        end
    end

    // serialized image of the updated shadow, byte 0 on top
    always_comb begin
        for (int i = 0; i < MAX_BYTES; i++) begin
            upl_data[(MAX_BYTES - 1 - i) * BYTE_BITS +: BYTE_BITS] = n_shadow[i];
        end
    end

    // classify the request into a command for the back
    always_comb begin
        has_res = 1'b0;
        nbits   = '0;
        data    = '0;
        ctl     = '0;
        unique case (i_action)
            ACT_SHIFT_BIT: begin
                has_res = 1'b1;
                nbits   = CNT_W'(1);
                data    = DATA_W'(i_value_bit) << (DATA_W - 1);
            end
            ACT_SHIFT_BYTE: begin
                has_res = 1'b1;
                nbits   = CNT_W'(BYTE_BITS);
                data    = DATA_W'(i_data_byte) << (DATA_W - BYTE_BITS);
            end
            ACT_LATCH: begin
                has_res   = 1'b1;
                ctl.latch = 1'b1;
            end
            ACT_WRITE_PIN: begin
                has_res   = pin_ok;
                nbits     = CNT_W'({len, 3'b000});
                data      = upl_data;
                ctl.latch = 1'b1;
            end
            ACT_MASK_BYTE: begin
                has_res   = (len4 != 4'd0) && i_final_item;
                nbits     = CNT_W'({len, 3'b000});
                data      = upl_data;
                ctl.latch = 1'b1;
            end
            ACT_READ_PIN: begin
                has_res    = 1'b1;
                ctl.rd     = 1'b1;
                ctl.level  = rd_level;
                ctl.analog = rd_level ? full_scale : 16'd0;
            end
            ACT_UPLOAD: begin
                has_res = len4 != 4'd0;
                nbits   = CNT_W'({len, 3'b000});
                data    = upl_data;
            end
            default: ;
        endcase
    end

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && has_res;
    assign o_entry    = {nbits, data, ctl};

    // shadow register, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BYTES; i++) begin
                r_shadow[i] <= 8'h00;
            end
        end else if (accept) begin
            r_shadow <= n_shadow;
        end
    end

endmodule

// File: hdl/sedrv_queue.sv
module sedrv_queue
    import sedrv_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = Q_DEPTH
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/sedrv_back.sv
module sedrv_back
    import sedrv_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF,
    localparam int DATA_W = MAX_BYTES * BYTE_BITS,
    localparam int CNT_W = $clog2(DATA_W + 1),
    localparam int ENT_W = CNT_W + DATA_W + $bits(t_tail_ctl)
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  logic [ENT_W-1:0] i_entry,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_kind,
    output logic             o_serial_bit,
    output logic             o_read_level,
    output logic [15:0]      o_read_analog,
    output logic             o_last
);

    localparam int CTL_W = $bits(t_tail_ctl);

    t_bk_state         r_state;
    t_bk_state         n_state;
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    t_tail_ctl         r_ctl;
    t_tail_ctl         n_ctl;

    logic              r_out_valid;
    logic [1:0]        r_kind;
    logic              r_sbit;
    logic              r_lvl;
    logic [15:0]       r_ana;
    logic              r_last;

    logic              slot_free;
    logic              emit;
    logic [1:0]        e_kind;
    logic              e_sbit;
    logic              e_lvl;
    logic [15:0]       e_ana;
    logic              e_last;

    logic [CNT_W-1:0]  ent_cnt;
    logic [DATA_W-1:0] ent_data;
    t_tail_ctl         ent_ctl;

    assign ent_cnt   = i_entry[ENT_W-1 -: CNT_W];
    assign ent_data  = i_entry[CTL_W +: DATA_W];
    assign ent_ctl   = t_tail_ctl'(i_entry[CTL_W-1:0]);
    assign slot_free = !r_out_valid || i_out_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command working registers
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_cnt  <= n_cnt;
        r_ctl  <= n_ctl;
    end

    // sequencer: serial bits first, then latch pulse or read reply
    always_comb begin
        n_state = r_state;
        n_data  = r_data;
        n_cnt   = r_cnt;
        n_ctl   = r_ctl;
        o_pop   = 1'b0;
        emit    = 1'b0;
        e_kind  = KIND_SERIAL;
        e_sbit  = 1'b0;
        e_lvl   = 1'b0;
        e_ana   = 16'd0;
        e_last  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_data  = ent_data;
                    n_cnt   = ent_cnt;
                    n_ctl   = ent_ctl;
                    n_state = (ent_cnt != '0) ? BK_BITS : BK_TAIL;
                end
            end
            BK_BITS: begin
                if (slot_free) begin
                    emit   = 1'b1;
                    e_kind = KIND_SERIAL;
                    e_sbit = r_data[DATA_W-1];
                    e_last = (r_cnt == CNT_W'(1)) && !r_ctl.latch && !r_ctl.rd;
                    n_data = r_data << 1;
                    n_cnt  = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = (r_ctl.latch || r_ctl.rd) ? BK_TAIL : BK_IDLE;
                    end
                end
            end
            BK_TAIL: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    n_state = BK_IDLE;
                    if (r_ctl.rd) begin
                        e_kind = KIND_READ;
                        e_lvl  = r_ctl.level;
                        e_ana  = r_ctl.analog;
                    end else begin
                        e_kind = KIND_LATCH;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= e_kind;
            r_sbit <= e_sbit;
            r_lvl  <= e_lvl;
            r_ana  <= e_ana;
            r_last <= e_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_serial_bit  = r_sbit;
    assign o_read_level  = r_lvl;
    assign o_read_analog = r_ana;
    assign o_last        = r_last;

    // a command in the bit phase always has bits left
    a_bits_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_BITS |-> r_cnt != '0)
        else $error("bit phase with empty bit count");

    // the queue is only popped when it holds a command
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_q_valid && r_state == BK_IDLE)
        else $error("pop from empty queue or busy back");

    // latch pulses and read replies always close their transaction
    a_tail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind != KIND_SERIAL |-> r_last)
        else $error("tail result without last");

    // a held result does not change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_kind) && $stable(r_last))
        else $error("stalled result changed");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import sedrv_pkg::*;
();

    localparam int         CHAIN_CAP     = MAX_BYTES_DEF;
    localparam logic [2:0] ACT_UNUSED    = 3'd7;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         SETTLE_CYCLES = 50;
    localparam int         REPORT_LIMIT  = 10;

    // one request transaction
    typedef struct {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic [4:0] pin;
        logic       value_bit;
        logic [1:0] byte_from_end;
        logic       final_item;
    } sedrv_req_t;

    // one line event transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic        serial_bit;
        logic        read_level;
        logic [15:0] read_analog;
        logic        last;
    } line_event_t;

    // shadow predictor and queue of expected line events
    class line_event_board;
        logic [7:0]  shadow [CHAIN_CAP];
        logic [2:0]  chain_bytes;
        logic [4:0]  analog_bits;
        line_event_t expected_events [$];
        line_event_t burst [$];
        int          requests;
        int          events_checked;
        int          faults;

        function new();
            foreach (shadow[k]) shadow[k] = 8'h00;
            chain_bytes    = CHAIN_BYTES_RST;
            analog_bits    = ANALOG_BITS_RST;
            requests       = 0;
            events_checked = 0;
            faults         = 0;
        endfunction

        function void load_reg(input logic idx, input logic [31:0] val);
            if (idx == REG_CHAIN_BYTES) begin
                chain_bytes = val[2:0];
            end else if (idx == REG_ANALOG_BITS) begin
                analog_bits = val[4:0];
            end
        endfunction

        // oversize chain acts as full capacity
        function int active_len();
            return (int'(chain_bytes) > CHAIN_CAP) ? CHAIN_CAP : int'(chain_bytes);
        endfunction

        function void add_event(input logic [1:0] kind, input logic sbit, input logic lvl,
                                input logic [15:0] ana);
            line_event_t e;
            e.kind        = kind;
            e.serial_bit  = sbit;
            e.read_level  = lvl;
            e.read_analog = ana;
            e.last        = 1'b0;
            burst.push_back(e);
        endfunction

        // msb first
        function void add_byte(input logic [7:0] v);
            int i;
            for (i = 7; i >= 0; i--) add_event(KIND_SERIAL, v[i], 1'b0, 16'h0000);
        endfunction

        // whole shadow, byte 0 first
        function void add_shadow(input int n);
            int i;
            for (i = 0; i < n; i++) add_byte(shadow[i]);
        endfunction

        function string fmt(input line_event_t e);
            return $sformatf("kind=%0d sbit=%0d lvl=%0d ana=%04h last=%0d",
                             e.kind, e.serial_bit, e.read_level, e.read_analog, e.last);
        endfunction

        function void note_fault(input string msg);
            faults++;
            if (faults <= REPORT_LIMIT) $display("%s", msg);
        endfunction

        function void note_request(input sedrv_req_t r);
            int          n;
            int          idx;
            int          b;
            int          i;
            logic        lvl;
            logic [15:0] ana;
            logic [7:0]  m;
            n = active_len();
            burst.delete();
            requests++;
            case (r.action)
                ACT_SHIFT_BIT: begin
                    if (n > 0) begin
                        for (i = 0; i < n - 1; i++)
                            shadow[i] = {shadow[i][6:0], shadow[i+1][7]};
                        shadow[n-1] = {shadow[n-1][6:0], r.value_bit};
                    end
                    add_event(KIND_SERIAL, r.value_bit, 1'b0, 16'h0000);
                end
                ACT_SHIFT_BYTE: begin
                    if (n > 0) begin
                        for (i = 0; i < n - 1; i++) shadow[i] = shadow[i+1];
                        shadow[n-1] = r.data_byte;
                    end
                    add_byte(r.data_byte);
                end
                ACT_LATCH: begin
                    add_event(KIND_LATCH, 1'b0, 1'b0, 16'h0000);
                end
                ACT_WRITE_PIN: begin
                    // pins beyond the chain are dropped without any event
                    if (n > 0 && int'(r.pin[4:3]) < n) begin
                        idx = n - int'(r.pin[4:3]) - 1;
                        m   = 8'h01 << r.pin[2:0];
                        shadow[idx] = r.value_bit ? (shadow[idx] | m) : (shadow[idx] & ~m);
                        add_shadow(n);
                        add_event(KIND_LATCH, 1'b0, 1'b0, 16'h0000);
                    end
                end
                ACT_MASK_BYTE: begin
                    if (n > 0) begin
                        // position past the chain leaves shadow alone but final still uploads
                        if (int'(r.byte_from_end) < n) begin
                            idx = n - int'(r.byte_from_end) - 1;
                            shadow[idx] = r.value_bit ? (shadow[idx] | r.data_byte)
                                                      : (shadow[idx] & ~r.data_byte);
                        end
                        if (r.final_item) begin
                            add_shadow(n);
                            add_event(KIND_LATCH, 1'b0, 1'b0, 16'h0000);
                        end
                    end
                end
                ACT_READ_PIN: begin
                    lvl = 1'b0;
                    ana = 16'h0000;
                    if (n > 0 && int'(r.pin[4:3]) < n) begin
                        idx = n - int'(r.pin[4:3]) - 1;
                        lvl = shadow[idx][r.pin[2:0]];
                    end
                    if (lvl) begin
                        // resolution clamped to the supported range
                        b = int'(analog_bits);
                        if (b < int'(ABITS_MIN)) b = int'(ABITS_MIN);
                        if (b > int'(ABITS_MAX)) b = int'(ABITS_MAX);
                        ana = 16'((32'd1 << b) - 1);
                    end
                    add_event(KIND_READ, 1'b0, lvl, ana);
                end
                ACT_UPLOAD: begin
                    add_shadow(n);
                end
                default: begin
                end
            endcase
            if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
            for (i = 0; i < burst.size(); i++) expected_events.push_back(burst[i]);
        endfunction

        function void check_line_event(input line_event_t got);
            line_event_t want;
            if (expected_events.size() == 0) begin
                note_fault({"line event with nothing pending: ", fmt(got)});
                return;
            end
            want = expected_events.pop_front();
            events_checked++;
            if (got.kind !== want.kind || got.serial_bit !== want.serial_bit ||
                got.read_level !== want.read_level || got.read_analog !== want.read_analog ||
                got.last !== want.last)
                note_fault({"line event mismatch: exp ", fmt(want), " got ", fmt(got)});
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_action;
    logic [7:0]  i_data_byte;
    logic [4:0]  i_pin;
    logic        i_value_bit;
    logic [1:0]  i_byte_from_end;
    logic        i_final_item;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic        o_serial_bit;
    logic        o_read_level;
    logic [15:0] o_read_analog;
    logic        o_last;

    line_event_board board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int settings_seen  = 1;

    sipo_expander_shadow_driver_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_pin           (i_pin),
        .i_value_bit     (i_value_bit),
        .i_byte_from_end (i_byte_from_end),
        .i_final_item    (i_final_item),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_serial_bit    (o_serial_bit),
        .o_read_level    (o_read_level),
        .o_read_analog   (o_read_analog),
        .o_last          (o_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("** sipo_expander_shadow_driver_core: FAILED **");
        $finish;
    end

    // receiver: random stalls plus one long hold on request
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge i_clk);
        end
    end

    // watch both channels
    always @(posedge i_clk) begin : monitor
        sedrv_req_t  req;
        line_event_t seen;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                req.action        = i_action;
                req.data_byte     = i_data_byte;
                req.pin           = i_pin;
                req.value_bit     = i_value_bit;
                req.byte_from_end = i_byte_from_end;
                req.final_item    = i_final_item;
                board.note_request(req);
            end
            if (o_out_valid && i_out_ready) begin
                seen.kind        = o_kind;
                seen.serial_bit  = o_serial_bit;
                seen.read_level  = o_read_level;
                seen.read_analog = o_read_analog;
                seen.last        = o_last;
                board.check_line_event(seen);
            end
        end
    end

    function automatic sedrv_req_t mk_req(input logic [2:0] action, input logic [7:0] data,
                                          input logic [4:0] pin, input logic vb,
                                          input logic [1:0] bfe, input logic fin);
        sedrv_req_t r;
        r.action        = action;
        r.data_byte     = data;
        r.pin           = pin;
        r.value_bit     = vb;
        r.byte_from_end = bfe;
        r.final_item    = fin;
        return r;
    endfunction

    // random content, pins mostly inside the current chain
    function automatic sedrv_req_t rand_req(input logic [2:0] action);
        sedrv_req_t r;
        int         n;
        n = board.active_len();
        r.action        = action;
        r.data_byte     = 8'($urandom_range(255));
        r.value_bit     = 1'($urandom_range(1));
        r.byte_from_end = 2'($urandom_range(3));
        r.final_item    = 1'($urandom_range(1));
        if (n > 0 && $urandom_range(99) < 75)
            r.pin = 5'($urandom_range(8 * n - 1));
        else
            r.pin = 5'($urandom_range(31));
        return r;
    endfunction

    task automatic send_item(input sedrv_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= r.action;
        i_data_byte     <= r.data_byte;
        i_pin           <= r.pin;
        i_value_bit     <= r.value_bit;
        i_byte_from_end <= r.byte_from_end;
        i_final_item    <= r.final_item;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // wait for every expected event, then let trailing no-event work finish
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.load_reg(idx, val);
        // return to idle before the next transfer
        @(posedge i_clk);
    endtask

    // extremes of every field and every request code on the reset configuration
    task automatic run_directed();
        send_item(mk_req(ACT_SHIFT_BYTE, 8'hFF, 5'd0, 1'b0, 2'd0, 1'b0));
        send_item(mk_req(ACT_SHIFT_BYTE, 8'h00, 5'd31, 1'b1, 2'd3, 1'b1));
        send_item(mk_req(ACT_SHIFT_BYTE, 8'hA5, 5'd0, 1'b0, 2'd0, 1'b0));
        send_item(mk_req(ACT_SHIFT_BIT, 8'h00, 5'd0, 1'b1, 2'd0, 1'b0));
        send_item(mk_req(ACT_SHIFT_BIT, 8'hFF, 5'd31, 1'b0, 2'd3, 1'b1));
        send_item(mk_req(ACT_LATCH, 8'h00, 5'd0, 1'b0, 2'd0, 1'b0));
        send_item(mk_req(ACT_WRITE_PIN, 8'h00, 5'd31, 1'b1, 2'd0, 1'b0));
        send_item(mk_req(ACT_WRITE_PIN, 8'h00, 5'd0, 1'b1, 2'd0, 1'b0));
        send_item(mk_req(ACT_WRITE_PIN, 8'hFF, 5'd0, 1'b0, 2'd3, 1'b1));
        send_item(mk_req(ACT_READ_PIN, 8'h00, 5'd31, 1'b0, 2'd0, 1'b0));
        send_item(mk_req(ACT_READ_PIN, 8'h00, 5'd0, 1'b0, 2'd0, 1'b0));
        send_item(mk_req(ACT_READ_PIN, 8'h00, 5'd13, 1'b0, 2'd0, 1'b0));
        // partial masked write at the chain end, then final items on byte 0 and an inner byte
        send_item(mk_req(ACT_MASK_BYTE, 8'hFF, 5'd0, 1'b1, 2'd0, 1'b0));
        send_item(mk_req(ACT_MASK_BYTE, 8'h0F, 5'd0, 1'b0, 2'd3, 1'b1));
        send_item(mk_req(ACT_MASK_BYTE, 8'hAA, 5'd0, 1'b1, 2'd2, 1'b1));
        send_item(mk_req(ACT_UPLOAD, 8'h00, 5'd0, 1'b0, 2'd0, 1'b0));
        send_item(mk_req(ACT_UNUSED, 8'hFF, 5'd31, 1'b1, 2'd3, 1'b1));
        send_item(mk_req(ACT_WRITE_PIN, 8'h00, 5'd7, 1'b1, 2'd1, 1'b0));
        send_item(mk_req(ACT_READ_PIN, 8'h00, 5'd7, 1'b1, 2'd0, 1'b0));
        send_item(mk_req(ACT_READ_PIN, 8'h00, 5'd24, 1'b0, 2'd0, 1'b0));
    endtask

    // masked-write bursts ending in a final item, some broken ones, mixed with single requests
    task automatic run_random(input int count);
        sedrv_req_t r;
        int         done;
        int         sel;
        int         burst_len;
        int         k;
        done = 0;
        while (done < count) begin
            sel = $urandom_range(99);
            if (sel < 25) begin
                burst_len = $urandom_range(4, 1);
                for (k = 0; k < burst_len; k++) begin
                    r = rand_req(ACT_MASK_BYTE);
                    if ($urandom_range(9) != 0) r.final_item = (k == burst_len - 1);
                    send_item(r);
                    done++;
                end
            end else begin
                if (sel < 37)      r = rand_req(ACT_SHIFT_BIT);
                else if (sel < 47) r = rand_req(ACT_SHIFT_BYTE);
                else if (sel < 53) r = rand_req(ACT_LATCH);
                else if (sel < 70) r = rand_req(ACT_WRITE_PIN);
                else if (sel < 88) r = rand_req(ACT_READ_PIN);
                else if (sel < 97) r = rand_req(ACT_UPLOAD);
                else               r = rand_req(ACT_UNUSED);
                send_item(r);
                if (r.action != ACT_UNUSED) done++;
            end
        end
    endtask

    task automatic run_phase(input logic [2:0] chain, input logic [4:0] abits,
                             input int send_pct, input int stall_pct, input bit hold,
                             input int count);
        write_reg(REG_CHAIN_BYTES, {29'd0, chain});
        write_reg(REG_ANALOG_BITS, {27'd0, abits});
        settings_seen++;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        if (hold) hold_req = 1'b1;
        run_random(count);
        settle();
    endtask

    // main sequence
    initial begin
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_in_valid      <= 1'b0;
        i_action        <= ACT_SHIFT_BIT;
        i_data_byte     <= '0;
        i_pin           <= '0;
        i_value_bit     <= 1'b0;
        i_byte_from_end <= '0;
        i_final_item    <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        settle();

        run_phase(3'd4, 5'd16, 0, 0, 1'b0, 100);
        run_phase(3'd1, 5'd1, 76, 0, 1'b0, 60);
        run_phase(3'd0, 5'd0, 0, 76, 1'b0, 40);
        run_phase(3'd7, 5'd31, 21, 21, 1'b0, 80);
        // long receiver hold with the sender pushing so the input backs up
        run_phase(3'd2, 5'd5, 0, 0, 1'b1, 50);
        run_phase(3'd3, 5'd17, 21, 21, 1'b0, 60);
        run_phase(3'd5, 5'd12, 0, 76, 1'b0, 45);

        board.faults += board.expected_events.size();
        $display("covered %0d requests and %0d line events over %0d register settings",
                 board.requests, board.events_checked, settings_seen);
        $display("chain lengths 0 to 7, analog resolution 0 to 31, idle and stall mixes");
        if (board.faults == 0) begin
            $display("** sipo_expander_shadow_driver_core: PASSED **");
        end else begin
            $display("** sipo_expander_shadow_driver_core: FAILED **");
        end
        $finish;
    end

endmodule
